/* rtl/cao_pkg.sv */
// Package for the cursor alpha overlay: register indexes, reset values, field widths
// and the premultiplied blend function for one colour byte.
// Depends on nothing; used by cursor_alpha_overlay.
package cao_pkg;

    // Default sizing of the position counters and the image bounds.
    localparam int IMAGE_DIM_BITS_DEFAULT  = 13;
    localparam int CURSOR_DIM_BITS_DEFAULT = 8;

    // Widths of the configuration fields and of the port data.
    localparam int CFG_DIM_W   = 14;
    localparam int CFG_CUR_W   = 9;
    localparam int CFG_PB_W    = 3;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 14;
    localparam int ADDR_OUT_W  = 28;

    // Register indexes on the configuration port.
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PIXEL_BYTES   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CURSOR_LEFT   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CURSOR_TOP    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_CURSOR_WIDTH  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_CURSOR_HEIGHT = 3'd6;

    // Reset values of the registers.
    localparam logic [CFG_DIM_W-1:0] RST_IMAGE_WIDTH   = 14'd1920;
    localparam logic [CFG_DIM_W-1:0] RST_IMAGE_HEIGHT  = 14'd1080;
    localparam logic [CFG_PB_W-1:0]  RST_PIXEL_BYTES   = 3'd4;
    localparam logic [CFG_DIM_W-1:0] RST_CURSOR_LEFT   = 14'd0;
    localparam logic [CFG_DIM_W-1:0] RST_CURSOR_TOP    = 14'd0;
    localparam logic [CFG_CUR_W-1:0] RST_CURSOR_WIDTH  = 9'd32;
    localparam logic [CFG_CUR_W-1:0] RST_CURSOR_HEIGHT = 9'd32;

    // Supported destination depths.
    localparam logic [CFG_PB_W-1:0] DEPTH_24 = 3'd3;
    localparam logic [CFG_PB_W-1:0] DEPTH_32 = 3'd4;

    localparam logic [7:0] ALPHA_OPAQUE = 8'd255;

    // src + round(dst * (255 - alpha) / 255), wrapping to eight bits.
    // The division by 255 uses (x + 1 + (x >> 8)) >> 8, exact over the range
    // that dst * (255 - alpha) + 127 can reach.
    function automatic logic [7:0] blend_byte(input logic [7:0] src,
                                              input logic [7:0] dst,
                                              input logic [7:0] alpha);
        logic [15:0] prod;
        logic [16:0] num;
        logic [16:0] approx;
        logic [7:0]  quot;
        prod   = 16'(dst) * 16'(ALPHA_OPAQUE - alpha);
        num    = 17'(prod) + 17'd127;
        approx = num + 17'd1 + (num >> 8);
        quot   = approx[15:8];
        return src + quot;
    endfunction

endpackage

/* rtl/cursor_alpha_overlay.sv */
// Cursor alpha overlay: premultiplied "over" blend of a cursor bitmap onto an image.
// Holds the configuration registers, the cursor position counters and both stages.
// Depends on cao_pkg.

// The block takes one cursor pixel per clock cycle in raster order, each with the
// three destination bytes beneath it, and returns one result transfer per input
// transfer, in order, through the input register and then the result register. It keeps
// the row and column position inside the cursor, clips each pixel against the
// image, and reports whether to write, the byte offset of the destination pixel
// and the new three bytes. A fully opaque pixel replaces the destination; a partly
// transparent one is blended with rounding; zero alpha, clipped pixels and a depth
// other than three or four bytes give no write, with address and bytes at zero.
// The last pixel of the cursor raises cursor_done and the counters return to the
// top left. Throughput is one pixel per cycle: the input register and the result
// register each take new data when they are empty or when their contents move on,
// so a stalled result lets the input register fill once and then holds the input
// off until the result is taken. The cycle time is set by
// the address path (row times image width, plus column, times the depth) and by
// the blend multiply with its constant division, both between the two registers.
// Configuration writes are taken in every cycle and must be made while the block
// holds no pixel and no pending result.
module cursor_alpha_overlay #(
    parameter int IMAGE_DIM_BITS  = cao_pkg::IMAGE_DIM_BITS_DEFAULT,
    parameter int CURSOR_DIM_BITS = cao_pkg::CURSOR_DIM_BITS_DEFAULT
) (
    input  logic                              aclk,
    input  logic                              aresetn,

    // Configuration write channel.
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [cao_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [cao_pkg::CFG_DATA_W-1:0]    cfg_data,

    // Cursor pixel stream.
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [31:0]                       s_cursor_pixel,
    input  logic [7:0]                        s_dest_byte0,
    input  logic [7:0]                        s_dest_byte1,
    input  logic [7:0]                        s_dest_byte2,

    // Write results.
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic                              m_write_enable,
    output logic [cao_pkg::ADDR_OUT_W-1:0]    m_byte_address,
    output logic [7:0]                        m_out_byte0,
    output logic [7:0]                        m_out_byte1,
    output logic [7:0]                        m_out_byte2,
    output logic                              m_cursor_done
);

    // Signed image position: a cursor edge plus a counter, one bit wider than the edge.
    localparam int POS_W  = cao_pkg::CFG_DIM_W + 1;
    // Width for comparing a non-negative position with a saturated image dimension.
    localparam int CMP_W  = (IMAGE_DIM_BITS + 1 > POS_W - 1) ? IMAGE_DIM_BITS + 1 : POS_W - 1;
    // Width for cursor dimensions after saturation and for counter plus one.
    localparam int CURW   = (CURSOR_DIM_BITS + 1 > cao_pkg::CFG_CUR_W) ?
                            CURSOR_DIM_BITS + 1 : cao_pkg::CFG_CUR_W;
    // Full width of the byte offset before it is cut to the port.
    localparam int ADDR_W = (2 * IMAGE_DIM_BITS + 4 > cao_pkg::ADDR_OUT_W) ?
                            2 * IMAGE_DIM_BITS + 4 : cao_pkg::ADDR_OUT_W;

    localparam logic [CMP_W-1:0] IMG_CAP = CMP_W'(1) << IMAGE_DIM_BITS;
    localparam logic [CURW-1:0]  CUR_CAP = CURW'(1) << CURSOR_DIM_BITS;

    // Configuration registers.
    logic        [cao_pkg::CFG_DIM_W-1:0] image_width_reg;
    logic        [cao_pkg::CFG_DIM_W-1:0] image_height_reg;
    logic        [cao_pkg::CFG_PB_W-1:0]  pixel_bytes_reg;
    logic signed [cao_pkg::CFG_DIM_W-1:0] cursor_left_reg;
    logic signed [cao_pkg::CFG_DIM_W-1:0] cursor_top_reg;
    logic        [cao_pkg::CFG_CUR_W-1:0] cursor_width_reg;
    logic        [cao_pkg::CFG_CUR_W-1:0] cursor_height_reg;

    // Position inside the cursor.
    logic [CURSOR_DIM_BITS-1:0] column_reg, column_next;
    logic [CURSOR_DIM_BITS-1:0] row_reg, row_next;

    // Input stage.
    logic                    s1_valid_reg;
    logic [31:0]             pixel_reg;
    logic [7:0]              dest0_reg, dest1_reg, dest2_reg;
    logic signed [POS_W-1:0] col_pos_reg, col_pos_next;
    logic signed [POS_W-1:0] row_pos_reg, row_pos_next;
    logic                    done_reg, done_next;

    // Result stage.
    logic                           m_valid_reg;
    logic                           we_reg, we_next;
    logic [cao_pkg::ADDR_OUT_W-1:0] addr_reg, addr_next;
    logic [7:0]                     out0_reg, out0_next;
    logic [7:0]                     out1_reg, out1_next;
    logic [7:0]                     out2_reg, out2_next;
    logic                           m_done_reg;

    logic s_accept;
    logic out_advance;
    logic s1_advance;

    logic [CURW-1:0]  cur_w, cur_h;
    logic             last_col, last_row;
    logic [CMP_W-1:0] img_w, img_h;
    logic             in_image, depth_ok;
    logic [7:0]       alpha;
    logic [ADDR_W-1:0] pix_index, byte_offset;

    // The result register moves on when it is empty or being taken; the input
    // register moves on when it is empty or its pixel goes into the result register.
    assign out_advance = !m_valid_reg || m_ready;
    assign s1_advance  = !s1_valid_reg || out_advance;
    assign s_ready     = s1_advance;
    assign s_accept    = s_valid && s1_advance;
    assign cfg_ready   = 1'b1;

    // Counter update and the image position of the pixel being taken in. A cursor
    // dimension of zero acts as one, and one beyond the counter range saturates.
    always_comb begin
        cur_w = (CURW'(cursor_width_reg) > CUR_CAP) ? CUR_CAP : CURW'(cursor_width_reg);
        cur_h = (CURW'(cursor_height_reg) > CUR_CAP) ? CUR_CAP : CURW'(cursor_height_reg);
        if (cur_w == '0) begin
            cur_w = CURW'(1);
        end
        if (cur_h == '0) begin
            cur_h = CURW'(1);
        end
        // A counter left beyond the bound by a register change counts as the last.
        last_col  = (CURW'(column_reg) + CURW'(1)) >= cur_w;
        last_row  = (CURW'(row_reg) + CURW'(1)) >= cur_h;
        done_next = last_col && last_row;

        column_next = column_reg;
        row_next    = row_reg;
        if (s_accept) begin
            if (done_next) begin
                column_next = '0;
                row_next    = '0;
            end else if (last_col) begin
                column_next = '0;
                row_next    = row_reg + CURSOR_DIM_BITS'(1);
            end else begin
                column_next = column_reg + CURSOR_DIM_BITS'(1);
            end
        end

        col_pos_next = POS_W'(cursor_left_reg) + POS_W'(column_reg);
        row_pos_next = POS_W'(cursor_top_reg) + POS_W'(row_reg);
    end

    // Clipping, address and blend between the input and result registers.
    always_comb begin
        img_w = (CMP_W'(image_width_reg) > IMG_CAP) ? IMG_CAP : CMP_W'(image_width_reg);
        img_h = (CMP_W'(image_height_reg) > IMG_CAP) ? IMG_CAP : CMP_W'(image_height_reg);
        in_image = !col_pos_reg[POS_W-1] && !row_pos_reg[POS_W-1]
                   && (CMP_W'(col_pos_reg[POS_W-2:0]) < img_w)
                   && (CMP_W'(row_pos_reg[POS_W-2:0]) < img_h);
        depth_ok = (pixel_bytes_reg == cao_pkg::DEPTH_24)
                   || (pixel_bytes_reg == cao_pkg::DEPTH_32);
        alpha    = pixel_reg[31:24];
        we_next  = in_image && depth_ok && (alpha != 8'd0);

        // Inside the image both positions fit in the image dimension bits.
        pix_index = ADDR_W'(row_pos_reg[IMAGE_DIM_BITS-1:0]) * ADDR_W'(img_w)
                    + ADDR_W'(col_pos_reg[IMAGE_DIM_BITS-1:0]);
        if (pixel_bytes_reg == cao_pkg::DEPTH_32) begin
            byte_offset = pix_index << 2;
        end else begin
            byte_offset = pix_index + (pix_index << 1);
        end

        addr_next = '0;
        out0_next = '0;
        out1_next = '0;
        out2_next = '0;
        if (we_next) begin
            addr_next = byte_offset[cao_pkg::ADDR_OUT_W-1:0];
            if (alpha == cao_pkg::ALPHA_OPAQUE) begin
                out0_next = pixel_reg[7:0];
                out1_next = pixel_reg[15:8];
                out2_next = pixel_reg[23:16];
            end else begin
                out0_next = cao_pkg::blend_byte(pixel_reg[7:0], dest0_reg, alpha);
                out1_next = cao_pkg::blend_byte(pixel_reg[15:8], dest1_reg, alpha);
                out2_next = cao_pkg::blend_byte(pixel_reg[23:16], dest2_reg, alpha);
            end
        end
    end

    // Control state and configuration.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            image_width_reg   <= cao_pkg::RST_IMAGE_WIDTH;
            image_height_reg  <= cao_pkg::RST_IMAGE_HEIGHT;
            pixel_bytes_reg   <= cao_pkg::RST_PIXEL_BYTES;
            cursor_left_reg   <= cao_pkg::RST_CURSOR_LEFT;
            cursor_top_reg    <= cao_pkg::RST_CURSOR_TOP;
            cursor_width_reg  <= cao_pkg::RST_CURSOR_WIDTH;
            cursor_height_reg <= cao_pkg::RST_CURSOR_HEIGHT;
            column_reg        <= '0;
            row_reg           <= '0;
            s1_valid_reg      <= 1'b0;
            m_valid_reg       <= 1'b0;
        end else begin
            if (cfg_valid) begin
                case (cfg_index)
                    cao_pkg::CFG_IMAGE_WIDTH:   image_width_reg   <= cfg_data;
                    cao_pkg::CFG_IMAGE_HEIGHT:  image_height_reg  <= cfg_data;
                    cao_pkg::CFG_PIXEL_BYTES:   pixel_bytes_reg   <= cfg_data[cao_pkg::CFG_PB_W-1:0];
                    cao_pkg::CFG_CURSOR_LEFT:   cursor_left_reg   <= cfg_data;
                    cao_pkg::CFG_CURSOR_TOP:    cursor_top_reg    <= cfg_data;
                    cao_pkg::CFG_CURSOR_WIDTH:  cursor_width_reg  <= cfg_data[cao_pkg::CFG_CUR_W-1:0];
                    cao_pkg::CFG_CURSOR_HEIGHT: cursor_height_reg <= cfg_data[cao_pkg::CFG_CUR_W-1:0];
                    default: begin
                    end
                endcase
            end
            column_reg <= column_next;
            row_reg    <= row_next;
            if (s1_advance) begin
                s1_valid_reg <= s_valid;
            end
            if (out_advance) begin
                m_valid_reg <= s1_valid_reg;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            pixel_reg   <= s_cursor_pixel;
            dest0_reg   <= s_dest_byte0;
            dest1_reg   <= s_dest_byte1;
            dest2_reg   <= s_dest_byte2;
            col_pos_reg <= col_pos_next;
            row_pos_reg <= row_pos_next;
            done_reg    <= done_next;
        end
        if (out_advance && s1_valid_reg) begin
            we_reg     <= we_next;
            addr_reg   <= addr_next;
            out0_reg   <= out0_next;
            out1_reg   <= out1_next;
            out2_reg   <= out2_next;
            m_done_reg <= done_reg;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_write_enable = we_reg;
    assign m_byte_address = addr_reg;
    assign m_out_byte0    = out0_reg;
    assign m_out_byte1    = out1_reg;
    assign m_out_byte2    = out2_reg;
    assign m_cursor_done  = m_done_reg;

`ifndef SYNTHESIS
    // The counters return to the top left after the last pixel of the cursor.
    a_done_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept && done_next |=> (column_reg == '0) && (row_reg == '0))
        else $error("cursor counters not cleared after the last pixel");

    // The counters move only on an input transfer.
    a_counters_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_accept |=> $stable(column_reg) && $stable(row_reg))
        else $error("cursor counters moved without an input transfer");

    // A pixel held in the input stage stays there while the result is stalled.
    a_stage_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        s1_valid_reg && !out_advance |=> s1_valid_reg && $stable(col_pos_reg)
                                         && $stable(row_pos_reg) && $stable(pixel_reg))
        else $error("input stage changed while the result was stalled");

    // A result without a write carries zero address and bytes.
    a_no_write_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && !we_reg |-> (addr_reg == '0) && (out0_reg == 8'd0)
                                   && (out1_reg == 8'd0) && (out2_reg == 8'd0))
        else $error("result without write carries a nonzero payload");
`endif

endmodule

/* tb/sv/cursor_alpha_overlay_tb.sv */
// Self-checking testbench for cursor_alpha_overlay: directed and random cursor pixels,
// predicted in step with the block and compared transfer by transfer on the result side.
// Depends on cao_pkg and cursor_alpha_overlay; needs nothing else.
`timescale 1ns / 1ps

module cursor_alpha_overlay_tb;

    // The block is built with its default sizing, so the predictor uses the same caps.
    localparam int unsigned IMG_CAP = 1 << cao_pkg::IMAGE_DIM_BITS_DEFAULT;
    localparam int unsigned CUR_CAP = 1 << cao_pkg::CURSOR_DIM_BITS_DEFAULT;
    localparam int          ADDR_W  = cao_pkg::ADDR_OUT_W;

    // A result passes through the input register and then the result register, so settling
    // for SETTLE_CYCLES after the last result leaves the pipeline empty.
    localparam int SETTLE_CYCLES  = 4;
    localparam int HOLD_CYCLES    = 96;
    // The longest legitimate silence is the receiver hold-off above, so a limit some
    // twenty times that catches a hang without cutting short a correct run.
    localparam int WATCHDOG_LIMIT = 2000;

    typedef struct packed {
        logic              write_enable;
        logic [ADDR_W-1:0] byte_address;
        logic [7:0]        out_byte0;
        logic [7:0]        out_byte1;
        logic [7:0]        out_byte2;
        logic              cursor_done;
    } overlay_write_t;

    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    logic                           cfg_valid = 1'b0;
    logic                           cfg_ready;
    logic [cao_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [cao_pkg::CFG_DATA_W-1:0] cfg_data  = '0;

    logic        s_valid        = 1'b0;
    logic        s_ready;
    logic [31:0] s_cursor_pixel = '0;
    logic [7:0]  s_dest_byte0   = '0;
    logic [7:0]  s_dest_byte1   = '0;
    logic [7:0]  s_dest_byte2   = '0;

    logic              m_valid;
    logic              m_ready = 1'b0;
    logic              m_write_enable;
    logic [ADDR_W-1:0] m_byte_address;
    logic [7:0]        m_out_byte0;
    logic [7:0]        m_out_byte1;
    logic [7:0]        m_out_byte2;
    logic              m_cursor_done;

    // Shadow copy of the registers and of the position inside the cursor.
    logic [cao_pkg::CFG_DIM_W-1:0] img_w    = cao_pkg::RST_IMAGE_WIDTH;
    logic [cao_pkg::CFG_DIM_W-1:0] img_h    = cao_pkg::RST_IMAGE_HEIGHT;
    logic [cao_pkg::CFG_PB_W-1:0]  depth    = cao_pkg::RST_PIXEL_BYTES;
    logic [cao_pkg::CFG_DIM_W-1:0] cur_left = cao_pkg::RST_CURSOR_LEFT;
    logic [cao_pkg::CFG_DIM_W-1:0] cur_top  = cao_pkg::RST_CURSOR_TOP;
    logic [cao_pkg::CFG_CUR_W-1:0] cur_w    = cao_pkg::RST_CURSOR_WIDTH;
    logic [cao_pkg::CFG_CUR_W-1:0] cur_h    = cao_pkg::RST_CURSOR_HEIGHT;
    logic [7:0]                    col_pos  = '0;
    logic [7:0]                    row_pos  = '0;

    overlay_write_t expected_writes[$];

    // Test control shared with the receiver: no_idle switches off random gaps on both
    // sides, and each step of hold_token starts one long receiver hold-off.
    logic no_idle    = 1'b0;
    int   hold_token = 0;
    int   hold_seen  = 0;
    int   hold_left  = 0;

    int mismatches         = 0;
    int pixels_sent        = 0;
    int regs_written       = 0;
    int cursors_done       = 0;
    int pixels_painted     = 0;
    int input_stall_cycles = 0;
    int silent_cycles      = 0;

    cursor_alpha_overlay u_top (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_cursor_pixel (s_cursor_pixel),
        .s_dest_byte0   (s_dest_byte0),
        .s_dest_byte1   (s_dest_byte1),
        .s_dest_byte2   (s_dest_byte2),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_write_enable (m_write_enable),
        .m_byte_address (m_byte_address),
        .m_out_byte0    (m_out_byte0),
        .m_out_byte1    (m_out_byte1),
        .m_out_byte2    (m_out_byte2),
        .m_cursor_done  (m_cursor_done)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------------

    function automatic int unsigned clamp_dim(input int unsigned v, input int unsigned cap,
                                              input int unsigned lowest);
        if (v > cap) return cap;
        if (v < lowest) return lowest;
        return v;
    endfunction

    // Over operator for one premultiplied channel, rounded and wrapped to a byte.
    function automatic logic [7:0] blend_channel(input logic [7:0] src, input logic [7:0] dst,
                                                 input logic [7:0] alpha);
        int unsigned scaled;
        scaled = (int'(dst) * (255 - int'(alpha)) + 127) / 255;
        return 8'(int'(src) + scaled);
    endfunction

    // Works out the write for one cursor pixel at the current position and then moves
    // the position on, exactly as the block's counters do.
    function automatic overlay_write_t predict_write(input logic [31:0] pix,
                                                     input logic [7:0] d0,
                                                     input logic [7:0] d1,
                                                     input logic [7:0] d2);
        overlay_write_t w;
        int unsigned    iw, ih, cw, ch;
        longint         col, row;
        logic [7:0]     alpha;
        logic           in_image, depth_ok, last_col, last_row;
        iw    = clamp_dim(img_w, IMG_CAP, 0);
        ih    = clamp_dim(img_h, IMG_CAP, 0);
        cw    = clamp_dim(cur_w, CUR_CAP, 1);
        ch    = clamp_dim(cur_h, CUR_CAP, 1);
        alpha = pix[31:24];
        col   = longint'($signed(cur_left)) + longint'(col_pos);
        row   = longint'($signed(cur_top)) + longint'(row_pos);
        in_image = col >= 0 && row >= 0 && col < longint'(iw) && row < longint'(ih);
        depth_ok = depth == cao_pkg::DEPTH_24 || depth == cao_pkg::DEPTH_32;
        last_col = int'(col_pos) + 1 >= cw;
        last_row = int'(row_pos) + 1 >= ch;

        w = '0;
        w.write_enable = in_image && depth_ok && alpha != 8'd0;
        if (w.write_enable) begin
            w.byte_address = ADDR_W'((row * longint'(iw) + col) * longint'(depth));
            if (alpha == cao_pkg::ALPHA_OPAQUE) begin
                w.out_byte0 = pix[7:0];
                w.out_byte1 = pix[15:8];
                w.out_byte2 = pix[23:16];
            end else begin
                w.out_byte0 = blend_channel(pix[7:0], d0, alpha);
                w.out_byte1 = blend_channel(pix[15:8], d1, alpha);
                w.out_byte2 = blend_channel(pix[23:16], d2, alpha);
            end
        end
        w.cursor_done = last_col && last_row;

        if (w.cursor_done) begin
            col_pos = '0;
            row_pos = '0;
        end else if (last_col) begin
            col_pos = '0;
            row_pos = row_pos + 8'd1;
        end else begin
            col_pos = col_pos + 8'd1;
        end
        return w;
    endfunction

    // ------------------------------------------------------------------------
    // Driving the block
    // ------------------------------------------------------------------------

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at %0t: %s", $realtime, msg);
        mismatches++;
    endtask

    // Register writes are only made while the block is empty; the shadow copy changes
    // at the edge that completes the transfer.
    task automatic write_reg(input logic [cao_pkg::CFG_IDX_W-1:0]  idx,
                             input logic [cao_pkg::CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        case (idx)
            cao_pkg::CFG_IMAGE_WIDTH:   img_w    = data;
            cao_pkg::CFG_IMAGE_HEIGHT:  img_h    = data;
            cao_pkg::CFG_PIXEL_BYTES:   depth    = data[cao_pkg::CFG_PB_W-1:0];
            cao_pkg::CFG_CURSOR_LEFT:   cur_left = data;
            cao_pkg::CFG_CURSOR_TOP:    cur_top  = data;
            cao_pkg::CFG_CURSOR_WIDTH:  cur_w    = data[cao_pkg::CFG_CUR_W-1:0];
            cao_pkg::CFG_CURSOR_HEIGHT: cur_h    = data[cao_pkg::CFG_CUR_W-1:0];
            default: ;
        endcase
        regs_written++;
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    // Offers one pixel and returns at the edge where it is taken. Valid is left high,
    // so back-to-back pixels need no second assignment in the same step; a random gap
    // before the next pixel is what lowers it.
    task automatic send_pixel(input logic [31:0] pix, input logic [7:0] d0,
                              input logic [7:0] d1, input logic [7:0] d2);
        while (!no_idle && $urandom_range(99) < 8) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_cursor_pixel <= pix;
        s_dest_byte0   <= d0;
        s_dest_byte1   <= d1;
        s_dest_byte2   <= d2;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        expected_writes.push_back(predict_write(pix, d0, d1, d2));
        pixels_sent++;
    endtask

    // The sender stops and waits until every predicted write has come out.
    task automatic wait_for_results();
        s_valid <= 1'b0;
        while (expected_writes.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Mostly premultiplied pixels, with some whose colour exceeds alpha so that the
    // sum wraps, and a fair share of fully transparent and fully opaque ones.
    function automatic logic [31:0] random_pixel();
        logic [7:0]  alpha;
        logic [23:0] rgb;
        case ($urandom_range(9))
            0:       alpha = 8'd0;
            1, 2:    alpha = cao_pkg::ALPHA_OPAQUE;
            default: alpha = 8'($urandom_range(1, 254));
        endcase
        rgb = 24'($urandom);
        if ($urandom_range(3) != 0) begin
            rgb[7:0]   = 8'($urandom_range(0, alpha));
            rgb[15:8]  = 8'($urandom_range(0, alpha));
            rgb[23:16] = 8'($urandom_range(0, alpha));
        end
        return {alpha, rgb};
    endfunction

    task automatic send_random_pixels(input int count);
        repeat (count) send_pixel(random_pixel(), 8'($urandom), 8'($urandom), 8'($urandom));
    endtask

    // Picks a whole new setting. Small images and cursors dominate so that most pixels
    // land near the edges; the extremes and raw 14-bit values come up regularly.
    task automatic randomise_config();
        logic [cao_pkg::CFG_DATA_W-1:0] v;
        for (int i = 0; i < 2; i++) begin
            case ($urandom_range(9))
                0:       v = 14'd0;
                1:       v = 14'd1;
                2:       v = 14'(IMG_CAP);
                3:       v = 14'h3FFF;
                4:       v = 14'($urandom);
                default: v = 14'($urandom_range(1, 48));
            endcase
            write_reg(i == 0 ? cao_pkg::CFG_IMAGE_WIDTH : cao_pkg::CFG_IMAGE_HEIGHT, v);
        end
        case ($urandom_range(9))
            0, 1, 2: v = 14'(cao_pkg::DEPTH_24);
            3, 4, 5: v = 14'(cao_pkg::DEPTH_32);
            6:       v = 14'($urandom);
            default: v = 14'($urandom_range(0, 7));
        endcase
        write_reg(cao_pkg::CFG_PIXEL_BYTES, v);
        for (int i = 0; i < 2; i++) begin
            case ($urandom_range(7))
                0:       v = 14'h2000;
                1:       v = 14'h1FFF;
                2:       v = 14'($urandom);
                default: v = 14'($urandom_range(0, 48)) - 14'd8;
            endcase
            write_reg(i == 0 ? cao_pkg::CFG_CURSOR_LEFT : cao_pkg::CFG_CURSOR_TOP, v);
        end
        for (int i = 0; i < 2; i++) begin
            case ($urandom_range(9))
                0:       v = 14'd0;
                1:       v = 14'(CUR_CAP);
                2:       v = 14'($urandom);
                3:       v = 14'd1;
                default: v = 14'($urandom_range(1, 12));
            endcase
            write_reg(i == 0 ? cao_pkg::CFG_CURSOR_WIDTH : cao_pkg::CFG_CURSOR_HEIGHT, v);
        end
    endtask

    // ------------------------------------------------------------------------
    // Result side
    // ------------------------------------------------------------------------

    // The receiver takes results with random stalls, or holds off completely for a
    // long stretch whenever a test steps hold_token.
    always @(posedge aclk) begin
        if (hold_token != hold_seen) begin
            hold_seen <= hold_token;
            hold_left <= HOLD_CYCLES;
            m_ready   <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_ready   <= 1'b0;
        end else begin
            m_ready <= no_idle || ($urandom_range(99) >= 8);
        end
    end

    // Every result transfer is matched against the oldest predicted write.
    always @(posedge aclk) begin : result_checker
        overlay_write_t got, want;
        if (aresetn && m_valid && m_ready) begin
            got.write_enable = m_write_enable;
            got.byte_address = m_byte_address;
            got.out_byte0    = m_out_byte0;
            got.out_byte1    = m_out_byte1;
            got.out_byte2    = m_out_byte2;
            got.cursor_done  = m_cursor_done;
            if (expected_writes.size() == 0) begin
                report_mismatch("result transfer with no pixel outstanding");
            end else begin
                want = expected_writes.pop_front();
                if (got.write_enable !== want.write_enable)
                    report_mismatch($sformatf("write_enable got %0b expected %0b",
                                              got.write_enable, want.write_enable));
                if (got.byte_address !== want.byte_address)
                    report_mismatch($sformatf("byte_address got %0h expected %0h",
                                              got.byte_address, want.byte_address));
                if (got.out_byte0 !== want.out_byte0)
                    report_mismatch($sformatf("out_byte0 got %0h expected %0h",
                                              got.out_byte0, want.out_byte0));
                if (got.out_byte1 !== want.out_byte1)
                    report_mismatch($sformatf("out_byte1 got %0h expected %0h",
                                              got.out_byte1, want.out_byte1));
                if (got.out_byte2 !== want.out_byte2)
                    report_mismatch($sformatf("out_byte2 got %0h expected %0h",
                                              got.out_byte2, want.out_byte2));
                if (got.cursor_done !== want.cursor_done)
                    report_mismatch($sformatf("cursor_done got %0b expected %0b",
                                              got.cursor_done, want.cursor_done));
            end
            if (got.cursor_done === 1'b1) cursors_done++;
            if (got.write_enable === 1'b1) pixels_painted++;
        end
    end

    // Watchdog: ends the run if no transfer of any kind happens for too long. It also
    // counts the cycles in which the block refuses an offered pixel.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
            silent_cycles <= 0;
        else
            silent_cycles <= silent_cycles + 1;
        if (aresetn && s_valid && !s_ready) input_stall_cycles <= input_stall_cycles + 1;
        if (silent_cycles >= WATCHDOG_LIMIT) begin
            $display("Timeout after %0d cycles without a transfer", silent_cycles);
            $display("Verification failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Reset values: a 32x32 cursor at the top left of a 1920x1080 four-byte image.
    // Covers opaque replacement, zero alpha, alpha one and 254, and a wrapping sum.
    task automatic test_reset_defaults();
        send_pixel(32'hFF10_2030, 8'h00, 8'h7F, 8'hFF);
        send_pixel(32'h00FF_FFFF, 8'h12, 8'h34, 8'h56);
        send_pixel(32'h0101_0101, 8'hFF, 8'hFF, 8'hFF);
        send_pixel(32'hFE00_0000, 8'hFF, 8'hFF, 8'hFF);
        send_pixel(32'h01FF_FFFF, 8'hFF, 8'hFF, 8'hFF);
        send_pixel(32'h0000_0000, 8'h00, 8'h00, 8'h00);
        wait_for_results();
    endtask

    // A one-pixel image with a 3x2 cursor hanging over its top left corner, so that
    // most of the cursor is clipped. The column counter is still at six from the test
    // before, which lies beyond the new width, so the first pixel closes the row.
    task automatic test_clipping();
        write_reg(cao_pkg::CFG_IMAGE_WIDTH, 14'd1);
        write_reg(cao_pkg::CFG_IMAGE_HEIGHT, 14'd1);
        write_reg(cao_pkg::CFG_PIXEL_BYTES, 14'(cao_pkg::DEPTH_24));
        write_reg(cao_pkg::CFG_CURSOR_LEFT, 14'h3FFF);
        write_reg(cao_pkg::CFG_CURSOR_TOP, 14'h3FFF);
        write_reg(cao_pkg::CFG_CURSOR_WIDTH, 14'd3);
        write_reg(cao_pkg::CFG_CURSOR_HEIGHT, 14'd2);
        send_pixel(32'h8080_8080, 8'h40, 8'h80, 8'hC0);
        send_pixel(32'h8070_6050, 8'h40, 8'h80, 8'hC0);
        send_pixel(32'h80FF_0000, 8'hFF, 8'h00, 8'hFF);
        send_pixel(32'hFFAA_5533, 8'h00, 8'h00, 8'h00);
        send_pixel(32'h7F7F_7F7F, 8'h01, 8'h02, 8'h03);
        send_pixel(32'hFF00_0000, 8'hEE, 8'hDD, 8'hCC);
        wait_for_results();
    endtask

    // An unsupported depth stops every write, even for a pixel inside the image;
    // zero cursor dimensions act as one, so each pixel ends the cursor. Then a zero
    // image height puts every pixel outside.
    task automatic test_depth_and_zero_dims();
        write_reg(cao_pkg::CFG_PIXEL_BYTES, 14'd0);
        write_reg(cao_pkg::CFG_CURSOR_LEFT, 14'd0);
        write_reg(cao_pkg::CFG_CURSOR_TOP, 14'd0);
        write_reg(cao_pkg::CFG_CURSOR_WIDTH, 14'd0);
        write_reg(cao_pkg::CFG_CURSOR_HEIGHT, 14'd0);
        send_pixel(32'hFF12_3456, 8'h11, 8'h22, 8'h33);
        send_pixel(32'h4020_1008, 8'h44, 8'h55, 8'h66);
        wait_for_results();
        write_reg(cao_pkg::CFG_PIXEL_BYTES, 14'(cao_pkg::DEPTH_24));
        write_reg(cao_pkg::CFG_IMAGE_HEIGHT, 14'd0);
        send_pixel(32'hFF65_4321, 8'h77, 8'h88, 8'h99);
        wait_for_results();
    endtask

    // Dimensions above the caps saturate: the image becomes 8192 square and the cursor
    // 256 square. The cursor starts on the last image pixel, giving the largest address,
    // and its second pixel falls off the right edge.
    task automatic test_oversized_dims();
        write_reg(cao_pkg::CFG_IMAGE_WIDTH, 14'h3FFF);
        write_reg(cao_pkg::CFG_IMAGE_HEIGHT, 14'h3FFF);
        write_reg(cao_pkg::CFG_PIXEL_BYTES, 14'(cao_pkg::DEPTH_32));
        write_reg(cao_pkg::CFG_CURSOR_LEFT, 14'h1FFF);
        write_reg(cao_pkg::CFG_CURSOR_TOP, 14'h1FFF);
        write_reg(cao_pkg::CFG_CURSOR_WIDTH, 14'd511);
        write_reg(cao_pkg::CFG_CURSOR_HEIGHT, 14'd511);
        send_pixel(32'h8040_2010, 8'hFF, 8'h80, 8'h00);
        send_pixel(32'hFFFF_FFFF, 8'h00, 8'h00, 8'h00);
        wait_for_results();
    endtask

    // The cursor shrinks while the counters are mid-way: first the width drops below
    // the column, which then counts as the end of a row, then the height drops to the
    // row index, which then counts as the end of the cursor.
    task automatic test_counter_overrun();
        write_reg(cao_pkg::CFG_CURSOR_LEFT, 14'd5);
        write_reg(cao_pkg::CFG_CURSOR_TOP, 14'd7);
        write_reg(cao_pkg::CFG_CURSOR_WIDTH, 14'd1);
        send_pixel(32'hC0A0_8060, 8'h10, 8'h20, 8'h30);
        wait_for_results();
        write_reg(cao_pkg::CFG_CURSOR_HEIGHT, 14'd1);
        send_pixel(32'hFF01_0203, 8'h40, 8'h50, 8'h60);
        wait_for_results();
    endtask

    // The bulk of the run: many short frames, each with a fresh setting. Frames end at
    // random points, so the counters often carry over into a smaller cursor.
    task automatic test_random_frames(input int frames);
        repeat (frames) begin
            randomise_config();
            send_random_pixels($urandom_range(80, 150));
            wait_for_results();
        end
    endtask

    // The receiver holds off for a long stretch while pixels keep coming, so the block
    // fills up and refuses input; afterwards the sender waits for the pipeline to drain.
    task automatic test_backpressure();
        write_reg(cao_pkg::CFG_IMAGE_WIDTH, 14'd40);
        write_reg(cao_pkg::CFG_IMAGE_HEIGHT, 14'd30);
        write_reg(cao_pkg::CFG_PIXEL_BYTES, 14'(cao_pkg::DEPTH_32));
        write_reg(cao_pkg::CFG_CURSOR_LEFT, 14'd35);
        write_reg(cao_pkg::CFG_CURSOR_TOP, 14'd26);
        write_reg(cao_pkg::CFG_CURSOR_WIDTH, 14'd8);
        write_reg(cao_pkg::CFG_CURSOR_HEIGHT, 14'd8);
        hold_token <= hold_token + 1;
        send_random_pixels(80);
        wait_for_results();
    endtask

    // A long stretch at full rate with no gaps on either side.
    task automatic test_full_rate_stream();
        no_idle <= 1'b1;
        write_reg(cao_pkg::CFG_IMAGE_WIDTH, 14'd20);
        write_reg(cao_pkg::CFG_IMAGE_HEIGHT, 14'd12);
        write_reg(cao_pkg::CFG_PIXEL_BYTES, 14'(cao_pkg::DEPTH_24));
        write_reg(cao_pkg::CFG_CURSOR_LEFT, 14'h3FFC);
        write_reg(cao_pkg::CFG_CURSOR_TOP, 14'd3);
        write_reg(cao_pkg::CFG_CURSOR_WIDTH, 14'd16);
        write_reg(cao_pkg::CFG_CURSOR_HEIGHT, 14'd12);
        send_random_pixels(250);
        wait_for_results();
        no_idle <= 1'b0;
    endtask

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_defaults();
        test_clipping();
        test_depth_and_zero_dims();
        test_oversized_dims();
        test_counter_overrun();
        test_random_frames(14);
        test_backpressure();
        test_full_rate_stream();

        wait_for_results();
        repeat (16) @(posedge aclk);

        $display("Covered %0d pixel transfers over %0d register writes, %0d cursors completed.",
                 pixels_sent, regs_written, cursors_done);
        $display("%0d pixels painted; input refused in %0d cycles under back-pressure.",
                 pixels_painted, input_stall_cycles);
        if (mismatches == 0) begin
            $display("Verification passed");
        end else begin
            $display("%0d mismatches found", mismatches);
            $display("Verification failed");
        end
        $finish;
    end

endmodule

/* files.f */
rtl/cao_pkg.sv
rtl/cursor_alpha_overlay.sv
tb/sv/cursor_alpha_overlay_tb.sv
